### rtl/llnp_pkg.sv
// Shared types and codes for the linked list node pool.
`timescale 1ns / 1ps

package llnp_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned HandleW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_HEAD_PUSH = 3'd1,
    CMD_TAIL_PUSH = 3'd2,
    CMD_INSERT    = 3'd3,
    CMD_HEAD_POP  = 3'd4,
    CMD_TAIL_POP  = 3'd5,
    CMD_DELETE    = 3'd6,
    CMD_FIND      = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_UNUSED   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SCAN_NEXT,
    DP_PUSH_HEAD,
    DP_ALLOC,
    DP_ALLOC_INS,
    DP_SEEK_HDL,
    DP_HEAD_POP,
    DP_STEP,
    DP_INS_A,
    DP_INS_B,
    DP_LINK_TAIL,
    DP_TAIL_POP,
    DP_DEL
  } dp_op_e;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_SCAN,
    SLOT_PTR
  } slot_sel_e;

  typedef struct packed {
    dp_op_e    op;
    logic      res_load;
    status_e   res_status;
    slot_sel_e slot_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_ok;
    logic hdl_ok;
    logic free_hit;
    logic scan_last;
    logic next_ok;
    logic walk_end;
    logic match;
  } dp_stat_t;

endpackage

### rtl/llnp_datapath.sv
// Node pool datapath: value and link memories, in-use marks, head, walk and scan registers.
`timescale 1ns / 1ps

module llnp_datapath import llnp_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                ctrl_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [HandleW-1:0]       handle_i,
  output dp_stat_t                 stat_o,
  output logic [StatusW-1:0]       status_o,
  output logic [SlotW-1:0]         slot_o
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = NW + 1;
  localparam logic [LW-1:0] NullLink = LW'(NODES);
  localparam logic [NW-1:0] LastSlot = NW'(NODES - 1);

  logic signed [ValueW-1:0] mem_val  [NODES];
  logic [LW-1:0]            mem_link [NODES];

  logic [NODES-1:0]         in_use_q;
  logic [LW-1:0]            head_q;
  logic [LW-1:0]            ptr_q, ptr_d;
  logic [LW-1:0]            prev_q;
  logic [LW-1:0]            cnt_q;
  logic [NW-1:0]            scan_q;
  logic [LW-1:0]            hdl_q;
  logic signed [ValueW-1:0] val_q;
  logic signed [ValueW-1:0] rd_val_q;
  logic [LW-1:0]            rd_link_q;
  logic [StatusW-1:0]       out_status_q;
  logic [SlotW-1:0]         out_slot_q;

  logic [LW-1:0]            hdl_link;
  logic [LW-1:0]            scan_ext;
  logic [LW-1:0]            next_link;
  logic                     next_ok;
  logic                     head_ok;
  logic                     hdl_ok;
  logic                     prev_null;
  logic                     link_we;
  logic [NW-1:0]            link_wa;
  logic [LW-1:0]            link_wd;
  logic                     val_we;
  logic [SlotW-1:0]         slot_pick;

  // Out-of-range handles map to the null link so they fail the in-use check.
  assign hdl_link = (32'(handle_i) < 32'(NODES)) ? LW'(handle_i) : NullLink;
  assign scan_ext = {1'b0, scan_q};

  assign head_ok   = (head_q < NullLink) && in_use_q[head_q[NW-1:0]];
  assign hdl_ok    = (hdl_q < NullLink) && in_use_q[hdl_q[NW-1:0]];
  assign next_ok   = (rd_link_q < NullLink) && in_use_q[rd_link_q[NW-1:0]];
  assign next_link = next_ok ? rd_link_q : NullLink;
  assign prev_null = (prev_q == NullLink);

  assign stat_o.head_ok   = head_ok;
  assign stat_o.hdl_ok    = hdl_ok;
  assign stat_o.free_hit  = !in_use_q[scan_q];
  assign stat_o.scan_last = (scan_q == LastSlot);
  assign stat_o.next_ok   = next_ok;
  assign stat_o.walk_end  = (cnt_q == NullLink);
  assign stat_o.match     = (rd_val_q == val_q);

  // Read data always follows the pointer register.
  always_comb begin
    unique case (ctrl_i.op)
      DP_LOAD:                   ptr_d = head_q;
      DP_SEEK_HDL, DP_ALLOC_INS: ptr_d = hdl_q;
      DP_STEP:                   ptr_d = next_link;
      default:                   ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = scan_q;
    link_wd = NullLink;
    val_we  = 1'b0;
    unique case (ctrl_i.op)
      DP_PUSH_HEAD: begin
        link_we = 1'b1;
        val_we  = 1'b1;
        link_wd = head_ok ? head_q : NullLink;
      end
      DP_ALLOC, DP_ALLOC_INS: begin
        link_we = 1'b1;
        val_we  = 1'b1;
      end
      DP_INS_A: begin
        link_we = 1'b1;
        link_wd = next_link;
      end
      DP_INS_B, DP_LINK_TAIL: begin
        link_we = 1'b1;
        link_wa = ptr_q[NW-1:0];
        link_wd = scan_ext;
      end
      DP_TAIL_POP: begin
        link_we = !prev_null;
        link_wa = prev_q[NW-1:0];
      end
      DP_DEL: begin
        link_we = 1'b1;
        link_wa = prev_q[NW-1:0];
        link_wd = next_link;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl_i.slot_sel)
      SLOT_SCAN: slot_pick = SlotW'(scan_q);
      SLOT_PTR:  slot_pick = SlotW'(ptr_q[NW-1:0]);
      default:   slot_pick = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      mem_link[link_wa] <= link_wd;
    end
    if (val_we) begin
      mem_val[scan_q] <= val_q;
    end
    rd_link_q <= mem_link[ptr_d[NW-1:0]];
    rd_val_q  <= mem_val[ptr_d[NW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      head_q   <= NullLink;
    end else begin
      unique case (ctrl_i.op)
        DP_CLEAR: begin
          in_use_q <= '0;
          head_q   <= NullLink;
        end
        DP_PUSH_HEAD: begin
          in_use_q[scan_q] <= 1'b1;
          head_q           <= scan_ext;
        end
        DP_ALLOC, DP_ALLOC_INS: begin
          in_use_q[scan_q] <= 1'b1;
        end
        DP_HEAD_POP: begin
          head_q                   <= next_link;
          in_use_q[ptr_q[NW-1:0]] <= 1'b0;
        end
        DP_TAIL_POP: begin
          if (prev_null) begin
            head_q <= NullLink;
          end
          in_use_q[ptr_q[NW-1:0]] <= 1'b0;
        end
        DP_DEL: begin
          in_use_q[ptr_q[NW-1:0]] <= 1'b0;
        end
        default: begin
          head_q <= head_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (ctrl_i.op == DP_LOAD) begin
      val_q  <= value_i;
      hdl_q  <= hdl_link;
      prev_q <= NullLink;
      cnt_q  <= '0;
      scan_q <= '0;
    end
    if (ctrl_i.op == DP_SCAN_NEXT) begin
      scan_q <= scan_q + 1'b1;
    end
    if (ctrl_i.op == DP_STEP) begin
      prev_q <= ptr_q;
      cnt_q  <= cnt_q + 1'b1;
    end
    if (ctrl_i.res_load) begin
      out_status_q <= ctrl_i.res_status;
      out_slot_q   <= slot_pick;
    end
  end

  assign status_o = out_status_q;
  assign slot_o   = out_slot_q;

endmodule

### rtl/llnp_ctrl.sv
// Command sequencer for the node pool: decodes a request and steps the datapath.
`timescale 1ns / 1ps

module llnp_ctrl import llnp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [CmdW-1:0] req_cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  input  dp_stat_t        stat_i,
  output ctrl_cmd_t       ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WALK,
    S_FIND,
    S_INS_A,
    S_INS_B,
    S_DEL_A,
    S_DEL_B,
    S_DONE
  } state_e;

  state_e    state_q, state_d;
  cmd_e      cmd_q, cmd_d;
  status_e   res_status_q, res_status_d;
  slot_sel_e slot_sel_q, slot_sel_d;
  logic      out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    cmd_d           = cmd_q;
    res_status_d    = res_status_q;
    slot_sel_d      = slot_sel_q;
    out_valid_d     = out_valid_q;
    ctrl_o.op         = DP_NOP;
    ctrl_o.res_load   = 1'b0;
    ctrl_o.res_status = res_status_q;
    ctrl_o.slot_sel   = slot_sel_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          ctrl_o.op = DP_LOAD;
          cmd_d     = cmd_e'(req_cmd_i);
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_d = STAT_OK;
        slot_sel_d   = SLOT_ZERO;
        unique case (cmd_q)
          CMD_CLEAR: begin
            ctrl_o.op = DP_CLEAR;
            state_d   = S_DONE;
          end
          CMD_HEAD_PUSH, CMD_TAIL_PUSH: begin
            state_d = S_SCAN;
          end
          CMD_INSERT: begin
            if (!stat_i.hdl_ok) begin
              res_status_d = STAT_UNUSED;
              state_d      = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
          CMD_HEAD_POP: begin
            if (!stat_i.head_ok) begin
              res_status_d = STAT_EMPTY;
            end else begin
              ctrl_o.op = DP_HEAD_POP;
            end
            state_d = S_DONE;
          end
          CMD_TAIL_POP: begin
            if (!stat_i.head_ok) begin
              res_status_d = STAT_EMPTY;
              state_d      = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end
          CMD_DELETE: begin
            if (!stat_i.hdl_ok) begin
              res_status_d = STAT_UNUSED;
              state_d      = S_DONE;
            end else begin
              ctrl_o.op = DP_SEEK_HDL;
              state_d   = S_DEL_A;
            end
          end
          CMD_FIND: begin
            if (!stat_i.head_ok) begin
              res_status_d = STAT_NOTFOUND;
              state_d      = S_DONE;
            end else begin
              state_d = S_FIND;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        priority if (stat_i.free_hit) begin
          slot_sel_d = SLOT_SCAN;
          unique case (cmd_q)
            CMD_HEAD_PUSH: begin
              ctrl_o.op = DP_PUSH_HEAD;
              state_d   = S_DONE;
            end
            CMD_TAIL_PUSH: begin
              if (!stat_i.head_ok) begin
                ctrl_o.op = DP_PUSH_HEAD;
                state_d   = S_DONE;
              end else begin
                ctrl_o.op = DP_ALLOC;
                state_d   = S_WALK;
              end
            end
            default: begin
              ctrl_o.op = DP_ALLOC_INS;
              state_d   = S_INS_A;
            end
          endcase
        end else if (stat_i.scan_last) begin
          res_status_d = STAT_FULL;
          state_d      = S_DONE;
        end else begin
          ctrl_o.op = DP_SCAN_NEXT;
        end
      end
      S_WALK: begin
        if (stat_i.next_ok && !stat_i.walk_end) begin
          ctrl_o.op = DP_STEP;
        end else if (cmd_q == CMD_TAIL_PUSH) begin
          ctrl_o.op = DP_LINK_TAIL;
          state_d   = S_DONE;
        end else begin
          ctrl_o.op = DP_TAIL_POP;
          state_d   = S_DONE;
        end
      end
      S_FIND: begin
        priority if (stat_i.walk_end) begin
          res_status_d = STAT_NOTFOUND;
          state_d      = S_DONE;
        end else if (stat_i.match) begin
          slot_sel_d = SLOT_PTR;
          state_d    = S_DONE;
        end else if (!stat_i.next_ok) begin
          res_status_d = STAT_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          ctrl_o.op = DP_STEP;
        end
      end
      S_INS_A: begin
        ctrl_o.op = DP_INS_A;
        state_d   = S_INS_B;
      end
      S_INS_B: begin
        ctrl_o.op = DP_INS_B;
        state_d   = S_DONE;
      end
      S_DEL_A: begin
        if (!stat_i.next_ok) begin
          res_status_d = STAT_EMPTY;
          state_d      = S_DONE;
        end else begin
          ctrl_o.op = DP_STEP;
          state_d   = S_DEL_B;
        end
      end
      S_DEL_B: begin
        ctrl_o.op = DP_DEL;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || res_ready_i) begin
          ctrl_o.res_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_CLEAR;
      res_status_q <= STAT_OK;
      slot_sel_q   <= SLOT_ZERO;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      res_status_q <= res_status_d;
      slot_sel_q   <= slot_sel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;

endmodule

### rtl/linked_list_node_pool.sv
// Top level of the linked list node pool: request and response streams around sequencer and datapath.
//
// A singly linked list kept in a pool of NODES slots. Each request on the slave
// stream carries a command in tuser and a value and handle in tdata; each request
// gives exactly one response on the master stream, carrying a status in tuser and
// a slot number in tdata. Requests are processed one at a time.
// Head push, tail push and insert first scan for the lowest free slot, one slot per
// cycle, up to NODES slots; tail push, tail pop and find walk the list from the head,
// one node per cycle through the link memory read port, up to NODES nodes.
// The response sits in an output register; a new request is taken while it waits,
// and a stalled receiver only holds the next response back. Reset empties the list
// and frees every slot at once; no clearing pass is needed.
`timescale 1ns / 1ps

module linked_list_node_pool import llnp_pkg::*; #(
  parameter int unsigned NODES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] handle, [39:36] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] slot, [7:4] zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);

  ctrl_cmd_t          ctrl;
  dp_stat_t           stat;
  logic [StatusW-1:0] res_status;
  logic [SlotW-1:0]   res_slot;

  llnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tuser[CmdW-1:0]),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  llnp_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .value_i  (s_axis_tdata[ValueW-1:0]),
    .handle_i (s_axis_tdata[ValueW+HandleW-1:ValueW]),
    .stat_o   (stat),
    .status_o (res_status),
    .slot_o   (res_slot)
  );

  assign m_axis_tdata = {4'b0000, res_slot};
  assign m_axis_tuser = res_status;

  // One request in flight: ready drops right after an accepted request.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another was in progress");

  // A response is only written when the output register is empty or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.res_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending response overwritten");

  // Failing or slotless results report slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata == 8'h00))
    else $error("nonzero slot on failing response");

endmodule

### dv/tb_top.sv
// Testbench for the linked list node pool: directed and random requests checked against a list model.
`timescale 1ns / 1ps

module tb_top;
  import llnp_pkg::*;

  localparam int unsigned PoolSize    = 16;
  localparam logic [4:0]  NullSlot    = 5'd16;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 2 * PoolSize + 8;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [31:0] value, [35:32] handle, [39:36] zero
  logic [2:0]  s_axis_tuser = '0;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [3:0] slot, [7:4] zero
  logic [2:0]  m_axis_tuser;        // [2:0] status

  // List model state
  logic [31:0] pool_val  [PoolSize];
  logic [4:0]  pool_link [PoolSize];
  logic [PoolSize-1:0] pool_used;
  logic [4:0]  head_ptr;

  resp_t       pending_q[$];
  int unsigned fail_count = 0;
  int unsigned req_count = 0;
  int unsigned resp_count = 0;
  int unsigned full_count = 0;
  int unsigned miss_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  cmd_e grow_cmds   [3] = '{CMD_HEAD_PUSH, CMD_TAIL_PUSH, CMD_INSERT};
  cmd_e shrink_cmds [3] = '{CMD_HEAD_POP, CMD_TAIL_POP, CMD_DELETE};

  linked_list_node_pool #(.NODES(PoolSize)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit live(input logic [4:0] s);
    return (s < NullSlot) && pool_used[s[3:0]];
  endfunction

  function automatic logic [4:0] next_of(input logic [4:0] s);
    logic [4:0] n;
    n = pool_link[s[3:0]];
    return live(n) ? n : NullSlot;
  endfunction

  // Take the lowest free slot, or return the null code when the pool is full.
  function automatic logic [4:0] alloc_slot(input logic [31:0] val);
    logic [4:0] s;
    int i;
    s = NullSlot;
    for (i = 0; i < PoolSize && s == NullSlot; i++)
      if (!pool_used[i]) s = 5'(i);
    if (s != NullSlot) begin
      pool_used[s[3:0]] = 1'b1;
      pool_val[s[3:0]]  = val;
      pool_link[s[3:0]] = NullSlot;
    end
    return s;
  endfunction

  function automatic resp_t apply_request(input cmd_e cmd, input logic [31:0] val,
                                          input logic [3:0] hdl);
    resp_t      r;
    logic [4:0] s, p, prev, h;
    int         steps;
    bit         found;
    r.status = STAT_OK;
    r.slot   = '0;
    h        = {1'b0, hdl};
    case (cmd)
      CMD_CLEAR: begin
        pool_used = '0;
        head_ptr  = NullSlot;
      end
      CMD_HEAD_PUSH: begin
        s = alloc_slot(val);
        if (s == NullSlot) begin
          r.status = STAT_FULL;
        end else begin
          pool_link[s[3:0]] = live(head_ptr) ? head_ptr : NullSlot;
          head_ptr = s;
          r.slot   = s[3:0];
        end
      end
      CMD_TAIL_PUSH: begin
        s = alloc_slot(val);
        if (s == NullSlot) begin
          r.status = STAT_FULL;
        end else begin
          if (!live(head_ptr)) begin
            head_ptr = s;
          end else begin
            p = head_ptr;
            for (steps = 0; steps < PoolSize && next_of(p) != NullSlot; steps++)
              p = next_of(p);
            pool_link[p[3:0]] = s;
          end
          r.slot = s[3:0];
        end
      end
      CMD_INSERT: begin
        if (!live(h)) begin
          r.status = STAT_UNUSED;
        end else begin
          s = alloc_slot(val);
          if (s == NullSlot) begin
            r.status = STAT_FULL;
          end else begin
            pool_link[s[3:0]] = next_of(h);
            pool_link[h[3:0]] = s;
            r.slot = s[3:0];
          end
        end
      end
      CMD_HEAD_POP: begin
        if (!live(head_ptr)) begin
          r.status = STAT_EMPTY;
        end else begin
          s = head_ptr;
          head_ptr = next_of(s);
          pool_used[s[3:0]] = 1'b0;
        end
      end
      CMD_TAIL_POP: begin
        if (!live(head_ptr)) begin
          r.status = STAT_EMPTY;
        end else begin
          p    = head_ptr;
          prev = NullSlot;
          for (steps = 0; steps < PoolSize && next_of(p) != NullSlot; steps++) begin
            prev = p;
            p    = next_of(p);
          end
          if (prev == NullSlot) head_ptr = NullSlot;
          else pool_link[prev[3:0]] = NullSlot;
          pool_used[p[3:0]] = 1'b0;
        end
      end
      CMD_DELETE: begin
        if (!live(h)) begin
          r.status = STAT_UNUSED;
        end else begin
          s = next_of(h);
          if (s == NullSlot) begin
            r.status = STAT_EMPTY;
          end else begin
            pool_link[h[3:0]] = next_of(s);
            pool_used[s[3:0]] = 1'b0;
          end
        end
      end
      default: begin
        r.status = STAT_NOTFOUND;
        found    = 1'b0;
        p        = live(head_ptr) ? head_ptr : NullSlot;
        for (steps = 0; steps < PoolSize && p != NullSlot && !found; steps++) begin
          if (pool_val[p[3:0]] == val) begin
            found    = 1'b1;
            r.status = STAT_OK;
            r.slot   = p[3:0];
          end else begin
            p = next_of(p);
          end
        end
      end
    endcase
    return r;
  endfunction

  // Drive one request and record its expected response once it is taken.
  task automatic send_req(input cmd_e cmd, input logic [31:0] val, input logic [3:0] hdl);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, hdl, val};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(apply_request(cmd, val, hdl));
    req_count++;
  endtask

  // Hold the request stream until every response is back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_used_slot();
    logic [3:0] s;
    s = 4'($urandom_range(PoolSize - 1));
    if (pool_used == '0) return s;
    while (!pool_used[s]) s = 4'($urandom_range(PoolSize - 1));
    return s;
  endfunction

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_req(CMD_CLEAR,     32'h0,         4'h0);
    send_req(CMD_HEAD_POP,  32'h0,         4'h0);
    send_req(CMD_TAIL_POP,  32'h0,         4'h0);
    send_req(CMD_FIND,      32'h0,         4'h0);
    send_req(CMD_DELETE,    32'h0,         4'hF);
    send_req(CMD_INSERT,    32'h1234_5678, 4'h0);
    send_req(CMD_HEAD_PUSH, 32'h7FFF_FFFF, 4'h0);
    send_req(CMD_TAIL_PUSH, 32'h8000_0000, 4'h0);
    send_req(CMD_INSERT,    32'hFFFF_FFFF, 4'h0);
    send_req(CMD_INSERT,    32'h0000_0001, 4'hA);
    send_req(CMD_FIND,      32'h8000_0000, 4'h0);
    send_req(CMD_FIND,      32'h0,         4'h0);
    send_req(CMD_DELETE,    32'h0,         4'h1);   // tail has nothing after it
    send_req(CMD_DELETE,    32'h0,         4'h0);
    send_req(CMD_HEAD_PUSH, 32'h5A5A_5A5A, 4'h0);
    send_req(CMD_TAIL_POP,  32'h0,         4'h0);
    send_req(CMD_HEAD_POP,  32'h0,         4'h0);
    send_req(CMD_TAIL_POP,  32'h0,         4'h0);   // single node left
    send_req(CMD_HEAD_POP,  32'h0,         4'h0);
  endtask

  // Fill every slot with repeated values, then hit the full pool and first-match find.
  task automatic test_pool_full();
    int i;
    send_req(CMD_CLEAR, 32'h0, 4'h0);
    for (i = 0; i < PoolSize; i++)
      send_req(i[0] ? CMD_TAIL_PUSH : CMD_HEAD_PUSH, 32'(i % 4), 4'h0);
    send_req(CMD_HEAD_PUSH, 32'hDEAD_BEEF, 4'h0);
    send_req(CMD_TAIL_PUSH, 32'hDEAD_BEEF, 4'h0);
    send_req(CMD_INSERT,    32'hDEAD_BEEF, 4'h5);
    send_req(CMD_FIND,      32'h2,         4'h0);
    send_req(CMD_FIND,      32'h3,         4'h0);
    send_req(CMD_TAIL_POP,  32'h0,         4'h0);
    send_req(CMD_INSERT,    32'h2,         4'h9);
    send_req(CMD_DELETE,    32'h0,         4'h9);
    send_req(CMD_CLEAR,     32'h0,         4'h0);
    send_req(CMD_FIND,      32'h2,         4'h0);
  endtask

  // Mostly well-formed traffic: grow and shrink in turns, handles and
  // search values taken from live nodes, with some noise on top.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                     input int unsigned stall);
    int   i, k;
    bit   grow;
    cmd_e cmd;
    logic [3:0]  hdl;
    logic [31:0] val;
    idle_pct  = idle;
    stall_pct = stall;
    grow      = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) grow = 1'($urandom_range(1));
      if (pool_used == '0) grow = 1'b1;
      k = $urandom_range(99);
      if (k < 2)       cmd = CMD_CLEAR;
      else if (k < 50) cmd = grow ? grow_cmds[$urandom_range(2)] : shrink_cmds[$urandom_range(2)];
      else if (k < 70) cmd = grow ? shrink_cmds[$urandom_range(2)] : grow_cmds[$urandom_range(2)];
      else if (k < 85) cmd = CMD_FIND;
      else             cmd = cmd_e'($urandom_range(7));
      hdl = ($urandom_range(9) < 8) ? pick_used_slot() : 4'($urandom_range(15));
      if (cmd == CMD_FIND && pool_used != '0 && $urandom_range(9) < 7)
        val = pool_val[pick_used_slot()];
      else
        val = rand_value();
      send_req(cmd, val, hdl);
    end
  endtask

  task automatic test_pressure_pause();
    test_random_traffic(100, 38, 38);
    wait_drained();
    test_random_traffic(100, 38, 38);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each response against the oldest expectation.
  always @(posedge clk_i) begin
    resp_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      resp_count++;
      if (pending_q.size() == 0) begin
        $error("unexpected response: status %0d slot %0d", m_axis_tuser, m_axis_tdata[3:0]);
        fail_count++;
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.status == STAT_FULL) full_count++;
        if (exp_r.status == STAT_NOTFOUND) miss_count++;
        if (m_axis_tuser !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[3:0] !== exp_r.slot) begin
          $error("slot mismatch: expected %0d, got %0d", exp_r.slot, m_axis_tdata[3:0]);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither stream moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("linked_list_node_pool verification failed");
      $finish;
    end
  end

  initial begin
    pool_used = '0;
    head_ptr  = NullSlot;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_pool_full();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 74, 0);
    test_pressure_pause();
    test_random_traffic(200, 0, 74);
    test_random_traffic(400, 38, 38);

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests under no, sender, receiver and mixed backpressure.",
             req_count);
    $display("Checked %0d responses: %0d pool-full and %0d not-found results.",
             resp_count, full_count, miss_count);
    if (fail_count == 0)
      $display("linked_list_node_pool verification clean");
    else
      $display("linked_list_node_pool verification failed");
    $finish;
  end

endmodule

### linked_list_node_pool.f
rtl/llnp_pkg.sv
rtl/llnp_datapath.sv
rtl/llnp_ctrl.sv
rtl/linked_list_node_pool.sv
dv/tb_top.sv
